// File: sv/tdpu_pkg.sv
// shared types, codes and the barrel shifter for the thumb data-processing unit
`default_nettype none

package tdpu_pkg;

	localparam int unsigned DataW   = 32;
	localparam int unsigned InstrW  = 16;
	localparam int unsigned RegIdxW = 3;
	localparam int unsigned NumRegs = 8;
	localparam int unsigned OutW    = 48;

	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} shift_t;

	typedef enum logic [1:0] {
		IMM_MOV = 2'd0,
		IMM_CMP = 2'd1,
		IMM_ADD = 2'd2,
		IMM_SUB = 2'd3
	} imm_op_t;

	typedef enum logic [3:0] {
		ALU_AND = 4'h0,
		ALU_EOR = 4'h1,
		ALU_LSL = 4'h2,
		ALU_LSR = 4'h3,
		ALU_ASR = 4'h4,
		ALU_ADC = 4'h5,
		ALU_SBC = 4'h6,
		ALU_ROR = 4'h7,
		ALU_TST = 4'h8,
		ALU_NEG = 4'h9,
		ALU_CMP = 4'ha,
		ALU_CMN = 4'hb,
		ALU_ORR = 4'hc,
		ALU_MUL = 4'hd,
		ALU_BIC = 4'he,
		ALU_MVN = 4'hf
	} alu_op_t;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

	typedef struct packed {
		logic             carry;
		logic [DataW-1:0] value;
	} shift_res_t;

	// arm barrel shifter; an amount of zero leaves value and carry alone
	function automatic shift_res_t barrel(input logic [DataW-1:0] v, input shift_t kind,
			input logic [7:0] n, input logic cin);
		logic [4:0]   m;
		logic         small_amt;
		logic [DataW:0] up;
		logic [DataW:0] dn;
		shift_res_t   r;
		m         = n[4:0];
		small_amt = (n[7:5] == 3'b000);
		up        = {1'b0, v} << m;
		dn        = {v, 1'b0} >> m;
		r.value   = v;
		r.carry   = cin;
		if (n != 8'd0) begin
			case (kind)
				SH_LSL: begin
					if (small_amt) begin
						r.value = v << m;
						r.carry = up[DataW];
					end else begin
						r.value = '0;
						r.carry = (n == 8'd32) ? v[0] : 1'b0;
					end
				end
				SH_LSR: begin
					if (small_amt) begin
						r.value = v >> m;
						r.carry = dn[0];
					end else begin
						r.value = '0;
						r.carry = (n == 8'd32) ? v[DataW-1] : 1'b0;
					end
				end
				SH_ASR: begin
					if (small_amt) begin
						r.value = $unsigned($signed(v) >>> m);
						r.carry = dn[0];
					end else begin
						r.value = {DataW{v[DataW-1]}};
						r.carry = v[DataW-1];
					end
				end
				SH_ROR: begin
					r.value = DataW'({v, v} >> m);
					r.carry = (m == 5'd0) ? v[DataW-1] : dn[0];
				end
				default: begin
					r.value = v;
					r.carry = cin;
				end
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/thumb_data_processing_unit.sv
// thumb low-register data-processing execute unit: register file, flags and alu
// an accepted item is held in stage s1, then in the result register on the master side
// throughput: one item per cycle unless m_tready stalls; operands are read from r0-r7
// as an item enters, with the executing item's write forwarded into that read
// the execute stage holds one 32x32 multiply, the barrel shifter and a 33-bit adder
// reset clears r0-r7, the nzcv flags and the valid bits of both pipeline stages
`default_nettype none

module thumb_data_processing_unit
	import tdpu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [InstrW-1:0] s_tdata,   // instruction[15:0]
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// handled[0], dest_written[1], dest_index[4:2], dest_value[36:5], flags_nzcv[40:37],
	// zero[47:41]
	output logic [OutW-1:0]        m_tdata
);

	typedef enum logic [2:0] {
		FMT_SHIFT,
		FMT_ADDSUB,
		FMT_IMM,
		FMT_ALU,
		FMT_NONE
	} fmt_t;

	// pipeline and state
	logic                   valid_s1;
	logic [InstrW-1:0]      instr_s1;
	logic [DataW-1:0]       opa_s1;
	logic [DataW-1:0]       opb_s1;
	logic [DataW-1:0]       regs_q [NumRegs];
	flags_t                 flags_q;
	logic                   out_valid_q;
	logic                   out_handled_q;
	logic                   out_wr_q;
	logic [RegIdxW-1:0]     out_rd_q;
	logic [DataW-1:0]       out_val_q;
	flags_t                 out_flags_q;

	logic                   advance;
	logic                   load_s1;
	logic [RegIdxW-1:0]     addr_a;
	logic [RegIdxW-1:0]     addr_b;

	fmt_t                   fmt;
	alu_op_t                alu_op;
	imm_op_t                imm_op;
	logic [DataW-1:0]       add_x;
	logic [DataW-1:0]       add_y;
	logic                   add_c;
	logic [DataW:0]         sum;
	flags_t                 arith_flags;
	shift_t                 sh_kind;
	logic [7:0]             sh_amt;
	shift_res_t             sh_res;
	logic [DataW-1:0]       product;
	logic [DataW-1:0]       rb_sel;

	logic                   ex_wr;
	logic [RegIdxW-1:0]     ex_rd;
	logic [DataW-1:0]       ex_val;
	flags_t                 ex_flags;
	logic                   ex_wr_en;

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign load_s1  = s_tvalid && s_tready;
	assign ex_wr_en = advance && ex_wr;

	// operand addresses of the incoming item
	always_comb begin
		if (s_tdata[15:13] == 3'b001) begin
			addr_a = s_tdata[10:8];
		end else if (s_tdata[15:10] == 6'b010000) begin
			addr_a = s_tdata[2:0];
		end else begin
			addr_a = s_tdata[5:3];
		end
		if (s_tdata[15:13] == 3'b000) begin
			addr_b = s_tdata[8:6];
		end else begin
			addr_b = s_tdata[5:3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// operand read, with the item now retiring forwarded
	always_ff @(posedge clk) begin
		if (load_s1) begin
			instr_s1 <= s_tdata;
			opa_s1   <= (ex_wr_en && ex_rd == addr_a) ? ex_val : regs_q[addr_a];
			opb_s1   <= (ex_wr_en && ex_rd == addr_b) ? ex_val : regs_q[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{default: '0};
		end else if (ex_wr_en) begin
			regs_q[ex_rd] <= ex_val;
		end
	end

	// decode
	always_comb begin
		if (instr_s1[15:13] == 3'b000 && instr_s1[12:11] == 2'b11) begin
			fmt = FMT_ADDSUB;
		end else if (instr_s1[15:13] == 3'b000) begin
			fmt = FMT_SHIFT;
		end else if (instr_s1[15:13] == 3'b001) begin
			fmt = FMT_IMM;
		end else if (instr_s1[15:10] == 6'b010000) begin
			fmt = FMT_ALU;
		end else begin
			fmt = FMT_NONE;
		end
	end

	assign alu_op = alu_op_t'(instr_s1[9:6]);
	assign imm_op = imm_op_t'(instr_s1[12:11]);
	assign rb_sel = instr_s1[10] ? {{(DataW-3){1'b0}}, instr_s1[8:6]} : opb_s1;

	// adder operands; subtraction is x + ~y + carry
	always_comb begin
		add_x = opa_s1;
		add_y = opb_s1;
		add_c = 1'b0;
		case (fmt)
			FMT_ADDSUB: begin
				add_y = instr_s1[9] ? ~rb_sel : rb_sel;
				add_c = instr_s1[9];
			end
			FMT_IMM: begin
				if (imm_op == IMM_ADD) begin
					add_y = {{(DataW-8){1'b0}}, instr_s1[7:0]};
				end else begin
					add_y = ~{{(DataW-8){1'b0}}, instr_s1[7:0]};
					add_c = 1'b1;
				end
			end
			FMT_ALU: begin
				case (alu_op)
					ALU_ADC: begin
						add_c = flags_q.c;
					end
					ALU_SBC: begin
						add_y = ~opb_s1;
						add_c = flags_q.c;
					end
					ALU_NEG: begin
						add_x = '0;
						add_y = ~opb_s1;
						add_c = 1'b1;
					end
					ALU_CMP: begin
						add_y = ~opb_s1;
						add_c = 1'b1;
					end
					default: begin
						add_c = 1'b0;
					end
				endcase
			end
			default: begin
				add_c = 1'b0;
			end
		endcase
	end

	assign sum           = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_c};
	assign arith_flags.n = sum[DataW-1];
	assign arith_flags.z = (sum[DataW-1:0] == '0);
	assign arith_flags.c = sum[DataW];
	assign arith_flags.v = (add_x[DataW-1] ^ sum[DataW-1]) & (add_y[DataW-1] ^ sum[DataW-1]);

	// shifter inputs: immediate lsr/asr of zero means 32
	always_comb begin
		if (fmt == FMT_ALU) begin
			case (alu_op)
				ALU_LSL: sh_kind = SH_LSL;
				ALU_LSR: sh_kind = SH_LSR;
				ALU_ASR: sh_kind = SH_ASR;
				default: sh_kind = SH_ROR;
			endcase
			sh_amt = opb_s1[7:0];
		end else begin
			sh_kind = shift_t'(instr_s1[12:11]);
			if (instr_s1[10:6] == 5'd0 && sh_kind != SH_LSL) begin
				sh_amt = 8'd32;
			end else begin
				sh_amt = {3'b000, instr_s1[10:6]};
			end
		end
	end

	assign sh_res  = barrel(opa_s1, sh_kind, sh_amt, flags_q.c);
	assign product = DataW'(opa_s1 * opb_s1);

	function automatic flags_t logic_flags(input logic [DataW-1:0] v, input logic c,
			input flags_t old);
		flags_t f;
		f.n = v[DataW-1];
		f.z = (v == '0);
		f.c = c;
		f.v = old.v;
		return f;
	endfunction

	// execute
	always_comb begin
		ex_wr    = 1'b0;
		ex_rd    = instr_s1[2:0];
		ex_val   = sum[DataW-1:0];
		ex_flags = flags_q;
		case (fmt)
			FMT_ADDSUB: begin
				ex_wr    = 1'b1;
				ex_flags = arith_flags;
			end
			FMT_SHIFT: begin
				ex_wr    = 1'b1;
				ex_val   = sh_res.value;
				ex_flags = logic_flags(sh_res.value, sh_res.carry, flags_q);
			end
			FMT_IMM: begin
				ex_rd = instr_s1[10:8];
				case (imm_op)
					IMM_MOV: begin
						ex_wr    = 1'b1;
						ex_val   = {{(DataW-8){1'b0}}, instr_s1[7:0]};
						ex_flags = logic_flags(ex_val, flags_q.c, flags_q);
					end
					IMM_CMP: begin
						ex_flags = arith_flags;
					end
					default: begin
						ex_wr    = 1'b1;
						ex_flags = arith_flags;
					end
				endcase
			end
			FMT_ALU: begin
				ex_wr = 1'b1;
				case (alu_op)
					ALU_AND: ex_val = opa_s1 & opb_s1;
					ALU_EOR: ex_val = opa_s1 ^ opb_s1;
					ALU_ORR: ex_val = opa_s1 | opb_s1;
					ALU_MUL: ex_val = product;
					ALU_BIC: ex_val = opa_s1 & ~opb_s1;
					ALU_MVN: ex_val = ~opb_s1;
					ALU_TST: begin
						ex_val = opa_s1 & opb_s1;
						ex_wr  = 1'b0;
					end
					ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: ex_val = sh_res.value;
					ALU_CMP, ALU_CMN: ex_wr = 1'b0;
					default: ex_val = sum[DataW-1:0];
				endcase
				case (alu_op)
					ALU_LSL, ALU_LSR, ALU_ASR, ALU_ROR: begin
						ex_flags = logic_flags(sh_res.value, sh_res.carry, flags_q);
					end
					ALU_ADC, ALU_SBC, ALU_NEG, ALU_CMP, ALU_CMN: begin
						ex_flags = arith_flags;
					end
					default: begin
						ex_flags = logic_flags(ex_val, flags_q.c, flags_q);
					end
				endcase
			end
			default: begin
				ex_wr = 1'b0;
			end
		endcase
	end

	// flags and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				flags_q <= ex_flags;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_handled_q <= (fmt != FMT_NONE);
			out_wr_q      <= ex_wr;
			out_rd_q      <= ex_wr ? ex_rd : '0;
			out_val_q     <= ex_wr ? ex_val : '0;
			out_flags_q   <= ex_flags;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OutW-41){1'b0}}, out_flags_q, out_val_q, out_rd_q, out_wr_q,
		out_handled_q};

endmodule

`default_nettype wire
